// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge, ignored while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/cfud_pkg.sv =====
// ---------------------------------------------------------------------------
// cfud_pkg
// Types, codes and calendar helpers for the up/down calendar clock setter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfud_pkg;

  // Direction codes
  localparam logic FUNC_UP   = 1'b0;
  localparam logic FUNC_DOWN = 1'b1;

  // Field select codes
  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_HOUR   = 3'd1;
  localparam logic [2:0] SEL_MINUTE = 3'd2;
  localparam logic [2:0] SEL_SECOND = 3'd3;
  localparam logic [2:0] SEL_MONTH  = 3'd4;
  localparam logic [2:0] SEL_DAY    = 3'd5;
  localparam logic [2:0] SEL_YEAR   = 3'd6;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [11:0] YEAR_MIN  = 12'd2016;
  localparam logic [11:0] YEAR_MAX  = 12'd3000;

  typedef struct packed {
    logic       func;
    logic [2:0] field_sel;
    logic       is_release;
  } req_t;

  typedef struct packed {
    logic [5:0]  out_second;
    logic [5:0]  out_minute;
    logic [4:0]  out_hour;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
  } rsp_t;

  // Gregorian leap rule over the year range in use: centuries not
  // divisible by 400 are common years.
  function automatic logic is_leap(input logic [11:0] y);
    logic century_common;
    century_common = y inside {12'd2100, 12'd2200, 12'd2300, 12'd2500,
                               12'd2600, 12'd2700, 12'd2900, 12'd3000};
    return (y[1:0] == 2'b00) && !century_common;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] mo,
                                               input logic [11:0] y);
    logic [4:0] dim;
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: dim = 5'd30;
      4'd2:                    dim = is_leap(y) ? 5'd29 : 5'd28;
      default:                 dim = 5'd31;
    endcase
    return dim;
  endfunction

endpackage

// ===== rtl/calendar_field_up_down_adjust.sv =====
// ---------------------------------------------------------------------------
// calendar_field_up_down_adjust
// Settable calendar clock stepped one field up or down per button request.
// ---------------------------------------------------------------------------
// Usage:
//   A request (req, req_valid/req_stall) carries the direction, the field
//   select and the release flag of one button event. Each accepted request
//   yields one response (rsp, rsp_valid/rsp_stall) holding the whole date
//   and time after the step; a non-release event or an empty select still
//   yields a response with the held values.
//   The response is registered in the output register or its skid entry.
//   One request per cycle while req_stall is low; the step and all carries
//   are settled combinationally from the calendar registers, so the next
//   request sees the updated date at once.
//   Reset (rst, synchronous) sets 1 January 2016, 00:00:00 and empties the
//   output register and skid entry.
//   When the receiver stalls, the response holds; one more request is taken
//   into the skid entry, after which req_stall rises until that entry drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module calendar_field_up_down_adjust
  import cfud_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  rsp_t cur;
  rsp_t cur_next;
  logic req_take;
  logic buf_full;

  assign req_stall = buf_full;
  assign req_take  = req_valid && !req_stall;

  cfud_step u_step (
    .cur (cur),
    .req (req),
    .nxt (cur_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.out_second <= 6'd0;
      cur.out_minute <= 6'd0;
      cur.out_hour   <= 5'd0;
      cur.out_day    <= 5'd1;
      cur.out_month  <= 4'd1;
      cur.out_year   <= YEAR_MIN;
    end else if (req_take) begin
      cur <= cur_next;
    end
  end

  cfud_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (req_take),
    .load_data (cur_next),
    .full      (buf_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `ASSERT_CLK(a_state_in_range, clk, rst,
    (cur.out_second <= SEC_MAX) && (cur.out_minute <= MIN_MAX) &&
    (cur.out_hour <= HOUR_MAX) && (cur.out_day >= 5'd1) &&
    (cur.out_month >= 4'd1) && (cur.out_month <= MONTH_MAX) &&
    (cur.out_year >= YEAR_MIN) && (cur.out_year <= YEAR_MAX))
  `ASSERT_CLK(a_no_release_holds, clk, rst,
    (req_take && !req.is_release) |=> (cur == $past(cur)))
  `ASSERT_CLK(a_second_up, clk, rst,
    (req_take && req.is_release && (req.func == FUNC_UP) &&
     (req.field_sel == SEL_SECOND) && (cur.out_second != SEC_MAX))
    |=> (cur.out_second == 6'($past(cur.out_second) + 6'd1)))

endmodule

// ===== rtl/cfud_step.sv =====
// ---------------------------------------------------------------------------
// cfud_step
// Next calendar state for one request: field step up or down with carries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfud_step
  import cfud_pkg::*;
(
  input  rsp_t cur,
  input  req_t req,
  output rsp_t nxt
);

  // up path
  logic        inc_s, inc_mi, inc_h, inc_d, inc_mo;
  logic        s_wrap, mi_wrap, h_wrap, mo_wrap_a, mo_wrap_b, d_carry;
  logic [3:0]  mo_a, mo_b;
  logic [11:0] y_a, y_b;
  logic [5:0]  d_a;
  rsp_t        up;

  // down path
  logic        dec_s, dec_mi, dec_h, dec_d, dec_mo, dec_y;
  logic        s_bor, mi_bor, h_bor, d_bor, mo_bor;
  logic [4:0]  d_c, dim_dn;
  logic [11:0] y_c;
  rsp_t        dn;

  logic        active;

  always_comb begin
    inc_s   = (req.field_sel == SEL_SECOND);
    s_wrap  = inc_s && (cur.out_second == SEC_MAX);
    inc_mi  = (req.field_sel == SEL_MINUTE) || s_wrap;
    mi_wrap = inc_mi && (cur.out_minute == MIN_MAX);
    inc_h   = (req.field_sel == SEL_HOUR) || mi_wrap;
    h_wrap  = inc_h && (cur.out_hour == HOUR_MAX);
    inc_d   = (req.field_sel == SEL_DAY) || h_wrap;
    inc_mo  = (req.field_sel == SEL_MONTH);

    up.out_second = s_wrap ? 6'd0 : 6'(cur.out_second + 6'(inc_s));
    up.out_minute = mi_wrap ? 6'd0 : 6'(cur.out_minute + 6'(inc_mi));
    up.out_hour   = h_wrap ? 5'd0 : 5'(cur.out_hour + 5'(inc_h));

    mo_wrap_a = inc_mo && (cur.out_month >= MONTH_MAX);
    mo_a      = mo_wrap_a ? 4'd1 : 4'(cur.out_month + 4'(inc_mo));
    y_a       = 12'(cur.out_year + 12'(req.field_sel == SEL_YEAR) + 12'(mo_wrap_a));

    // day past the month length wraps to the first and carries into month
    d_a       = 6'(cur.out_day) + 6'(inc_d);
    d_carry   = d_a > 6'(days_in_month(mo_a, y_a));
    up.out_day = d_carry ? 5'd1 : d_a[4:0];
    mo_b      = 4'(mo_a + 4'(d_carry));
    mo_wrap_b = mo_b > MONTH_MAX;
    up.out_month = mo_wrap_b ? 4'd1 : mo_b;
    y_b       = 12'(y_a + 12'(mo_wrap_b));
    if (y_b >= YEAR_MAX) begin
      up.out_year = YEAR_MAX;
    end else if (y_b < YEAR_MIN) begin
      up.out_year = YEAR_MIN;
    end else begin
      up.out_year = y_b;
    end

    dec_s  = (req.field_sel == SEL_SECOND);
    s_bor  = dec_s && (cur.out_second == 6'd0);
    dec_mi = (req.field_sel == SEL_MINUTE) || s_bor;
    mi_bor = dec_mi && (cur.out_minute == 6'd0);
    dec_h  = (req.field_sel == SEL_HOUR) || mi_bor;
    h_bor  = dec_h && (cur.out_hour == 5'd0);
    dec_d  = (req.field_sel == SEL_DAY) || h_bor;
    d_bor  = dec_d && (cur.out_day <= 5'd1);
    dec_mo = (req.field_sel == SEL_MONTH) || d_bor;
    mo_bor = dec_mo && (cur.out_month <= 4'd1);
    dec_y  = ((req.field_sel == SEL_YEAR) || mo_bor) && (cur.out_year != 12'd0);

    dn.out_second = s_bor ? SEC_MAX : 6'(cur.out_second - 6'(dec_s));
    dn.out_minute = mi_bor ? MIN_MAX : 6'(cur.out_minute - 6'(dec_mi));
    dn.out_hour   = h_bor ? HOUR_MAX : 5'(cur.out_hour - 5'(dec_h));
    d_c           = d_bor ? 5'd0 : 5'(cur.out_day - 5'(dec_d));
    dn.out_month  = mo_bor ? MONTH_MAX : 4'(cur.out_month - 4'(dec_mo));
    y_c           = 12'(cur.out_year - 12'(dec_y));
    dn.out_year   = (y_c < YEAR_MIN) ? YEAR_MIN : y_c;

    // borrowed or too-large day lands on the last day of the month
    dim_dn    = days_in_month(dn.out_month, dn.out_year);
    dn.out_day = ((d_c == 5'd0) || (d_c > dim_dn)) ? dim_dn : d_c;

    active = req.is_release && (req.field_sel != SEL_NONE) && (req.field_sel <= SEL_YEAR);
    if (!active) begin
      nxt = cur;
    end else if (req.func == FUNC_UP) begin
      nxt = up;
    end else begin
      nxt = dn;
    end
  end

endmodule

// ===== rtl/cfud_out_buf.sv =====
// ---------------------------------------------------------------------------
// cfud_out_buf
// Result register with one skid entry between the update and the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cfud_out_buf
  import cfud_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  rsp_t load_data,
  output logic full,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic skid_valid;
  rsp_t skid;
  logic slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        // drain the skid entry first; no load can arrive while it is full
        rsp        <= skid;
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp       <= load_data;
        rsp_valid <= load;
      end
    end else if (load) begin
      skid       <= load_data;
      skid_valid <= 1'b1;
    end
  end

  `ASSERT_CLK(a_skid_implies_out, clk, rst, skid_valid |-> rsp_valid)
  `ASSERT_CLK(a_stalled_load_to_skid, clk, rst,
    (rsp_valid && rsp_stall && !skid_valid && load) |=> skid_valid)
  `ASSERT_CLK(a_skid_drains, clk, rst, (skid_valid && !rsp_stall) |=> !skid_valid)

endmodule

// ===== test/tb_calendar_field_up_down_adjust.sv =====
// ---------------------------------------------------------------------------
// tb_calendar_field_up_down_adjust
// Drives button requests into the calendar setter and checks every response
// against a cycle-free calendar predictor kept in the testbench: directed
// carry, borrow and leap cases, a random walk, a long output hold-off that
// fills the block, and a closing stretch of back-to-back requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calendar_field_up_down_adjust;
  import cfud_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 450;
  localparam int HOLD_CYCLES    = 40;
  localparam int PRESSURE_ITEMS = 24;
  localparam int FINAL_ITEMS    = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 1000;

  // Select code outside the field list; the block must ignore it.
  localparam logic [2:0] SEL_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  calendar_field_up_down_adjust uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Predicted calendar, starting at 1 January 2016, 00:00:00.
  logic [5:0]  cal_second = '0;
  logic [5:0]  cal_minute = '0;
  logic [4:0]  cal_hour   = '0;
  logic [4:0]  cal_day    = 5'd1;
  logic [3:0]  cal_month  = 4'd1;
  logic [11:0] cal_year   = YEAR_MIN;

  rsp_t expected_dates[$];
  int   mismatch_count = 0;
  bit   sender_idles = 1'b1;
  bit   receiver_idles = 1'b1;
  bit   hold_off_pending = 1'b0;
  int   stall_burst;

  wire req_taken = req_valid && !req_stall;
  wire rsp_taken = rsp_valid && !rsp_stall;

  function automatic int month_length(input int mo, input int y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    if (mo == 2) return leap ? 29 : 28;
    return 31;
  endfunction

  // Apply one button event to the predicted calendar; return the new date.
  function automatic rsp_t apply_press(input req_t press);
    int   s, mi, h, d, mo, y;
    bit   s_b, mi_b, h_b, d_b, mo_b;
    rsp_t date;
    s = int'(cal_second);
    mi = int'(cal_minute);
    h = int'(cal_hour);
    d = int'(cal_day);
    mo = int'(cal_month);
    y = int'(cal_year);
    s_b = 1'b0;
    mi_b = 1'b0;
    h_b = 1'b0;
    d_b = 1'b0;
    mo_b = 1'b0;
    if (press.is_release && press.field_sel != SEL_NONE &&
        press.field_sel != SEL_UNUSED) begin
      if (press.func == FUNC_UP) begin
        case (press.field_sel)
          SEL_HOUR:   h++;
          SEL_MINUTE: mi++;
          SEL_SECOND: s++;
          SEL_MONTH:  mo++;
          SEL_DAY:    d++;
          SEL_YEAR:   y++;
          default: ;
        endcase
        if (s > int'(SEC_MAX)) begin s = 0; mi++; end
        if (mi > int'(MIN_MAX)) begin mi = 0; h++; end
        if (h > int'(HOUR_MAX)) begin h = 0; d++; end
        if (mo > int'(MONTH_MAX)) begin mo = 1; y++; end
        // a month or year step can also leave the day past the month end
        if (d > month_length(mo, y)) begin d = 1; mo++; end
        if (mo > int'(MONTH_MAX)) begin mo = 1; y++; end
        if (y > int'(YEAR_MAX)) y = int'(YEAR_MAX);
        if (y < int'(YEAR_MIN)) y = int'(YEAR_MIN);
      end else begin
        case (press.field_sel)
          SEL_HOUR:   h_b = 1'b1;
          SEL_MINUTE: mi_b = 1'b1;
          SEL_SECOND: s_b = 1'b1;
          SEL_MONTH:  mo_b = 1'b1;
          SEL_DAY:    d_b = 1'b1;
          SEL_YEAR:   if (y > 0) y--;
          default: ;
        endcase
        if (s_b) begin
          if (s == 0) begin s = int'(SEC_MAX); mi_b = 1'b1; end else s--;
        end
        if (mi_b) begin
          if (mi == 0) begin mi = int'(MIN_MAX); h_b = 1'b1; end else mi--;
        end
        if (h_b) begin
          if (h == 0) begin h = int'(HOUR_MAX); d_b = 1'b1; end else h--;
        end
        if (d_b) begin
          if (d <= 1) begin d = 0; mo_b = 1'b1; end else d--;
        end
        if (mo_b) begin
          if (mo <= 1) begin
            mo = int'(MONTH_MAX);
            if (y > 0) y--;
          end else begin
            mo--;
          end
        end
        if (y < int'(YEAR_MIN)) y = int'(YEAR_MIN);
        // borrowed day goes to the month end; an overlong day is clamped
        if (d == 0 || d > month_length(mo, y)) d = month_length(mo, y);
      end
      cal_second = 6'(s);
      cal_minute = 6'(mi);
      cal_hour = 5'(h);
      cal_day = 5'(d);
      cal_month = 4'(mo);
      cal_year = 12'(y);
    end
    date.out_second = cal_second;
    date.out_minute = cal_minute;
    date.out_hour = cal_hour;
    date.out_day = cal_day;
    date.out_month = cal_month;
    date.out_year = cal_year;
    return date;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one request, with an optional idle burst first; returns at a falling edge.
  task automatic send_press(input logic dir, input logic [2:0] sel, input logic rel);
    req_t item;
    int   gap;
    item.func = dir;
    item.field_sel = sel;
    item.is_release = rel;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_dates.push_back(apply_press(item));
    @(negedge clk);
  endtask

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  always begin : receiver_stall
    @(negedge clk);
    if (hold_off_pending) begin
      rsp_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_off_pending = 1'b0;
      rsp_stall <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
      stall_burst = $urandom_range(1, 6);
      rsp_stall <= 1'b1;
      repeat (stall_burst) @(negedge clk);
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : response_check
    rsp_t want;
    if (!rst && rsp_taken) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: response with none pending, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, rsp.out_year, rsp.out_month, rsp.out_day,
                 rsp.out_hour, rsp.out_minute, rsp.out_second);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("second", 12'(want.out_second), 12'(rsp.out_second));
        check_field("minute", 12'(want.out_minute), 12'(rsp.out_minute));
        check_field("hour", 12'(want.out_hour), 12'(rsp.out_hour));
        check_field("day", 12'(want.out_day), 12'(rsp.out_day));
        check_field("month", 12'(want.out_month), 12'(rsp.out_month));
        check_field("year", want.out_year, rsp.out_year);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (req_taken || rsp_taken) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Ignored events, full carry and borrow chains, leap and month-end cases.
  task automatic test_directed_cases();
    send_press(FUNC_UP, SEL_NONE, 1'b1);
    send_press(FUNC_DOWN, SEL_UNUSED, 1'b1);
    send_press(FUNC_UP, SEL_YEAR, 1'b0);
    send_press(FUNC_DOWN, SEL_SECOND, 1'b1);   // borrow through every field
    send_press(FUNC_UP, SEL_SECOND, 1'b1);     // carry through every field
    send_press(FUNC_DOWN, SEL_MINUTE, 1'b1);
    send_press(FUNC_UP, SEL_MINUTE, 1'b1);
    send_press(FUNC_DOWN, SEL_HOUR, 1'b1);
    send_press(FUNC_UP, SEL_HOUR, 1'b1);
    send_press(FUNC_DOWN, SEL_DAY, 1'b1);
    send_press(FUNC_UP, SEL_MONTH, 1'b1);      // December to January
    send_press(FUNC_UP, SEL_MONTH, 1'b1);      // 31 January into February
    send_press(FUNC_DOWN, SEL_DAY, 1'b1);
    send_press(FUNC_DOWN, SEL_YEAR, 1'b1);
    send_press(FUNC_UP, SEL_DAY, 1'b1);        // 29 February of a leap year
    send_press(FUNC_UP, SEL_YEAR, 1'b1);       // leap day into a common year
    send_press(FUNC_DOWN, SEL_MONTH, 1'b1);
    send_press(FUNC_DOWN, SEL_MONTH, 1'b1);
    send_press(FUNC_DOWN, SEL_DAY, 1'b1);
    send_press(FUNC_DOWN, SEL_MONTH, 1'b1);    // 31 into a 30-day month
    send_press(FUNC_UP, SEL_DAY, 1'b1);
    send_press(FUNC_DOWN, SEL_YEAR, 1'b1);     // year floor
    send_press(FUNC_DOWN, SEL_HOUR, 1'b0);
    send_press(FUNC_UP, SEL_UNUSED, 1'b0);
  endtask

  task automatic test_random_presses();
    logic       dir;
    logic [2:0] sel;
    logic       rel;
    repeat (RANDOM_ITEMS) begin
      dir = 1'($urandom_range(0, 1));
      sel = 3'($urandom_range(0, 7));
      rel = ($urandom_range(0, 9) != 0);
      send_press(dir, sel, rel);
    end
  endtask

  // Hold the output for a long stretch while requests keep coming.
  task automatic test_output_hold_off();
    sender_idles = 1'b0;
    hold_off_pending = 1'b1;
    repeat (PRESSURE_ITEMS)
      send_press(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Back-to-back requests on both sides; no idling from here on.
  task automatic test_back_to_back();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    repeat (FINAL_ITEMS)
      send_press(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_presses();
    test_output_hold_off();
    test_back_to_back();
    req_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cfud_pkg.sv
rtl/cfud_step.sv
rtl/cfud_out_buf.sv
rtl/calendar_field_up_down_adjust.sv
test/tb_calendar_field_up_down_adjust.sv
